// ===== sv/tpct_pkg.sv =====
// ----------------------------------------------------------------------------
// tpct_pkg: shared types and constants for the twin prime candidate test
// Widths of the value path, trial engine handshakes and fixed trial seeds.
// ----------------------------------------------------------------------------
`default_nettype none

package tpct_pkg;

    localparam int VALUE_WIDTH = 32;
    // n+1 needs one bit more than n
    localparam int VAL_EXT_W   = VALUE_WIDTH + 1;
    // running square of the trial divisor may pass m once before the stop
    localparam int SQ_W        = VAL_EXT_W + 1;
    localparam int REM_CNT_W   = $clog2(VAL_EXT_W + 1);
    localparam int CNT_W       = 32;
    localparam int MEMBER_W    = 32;

    localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((MEMBER_W + CNT_W + 7) / 8) * 8;

    // first trial divisor and its square
    localparam logic [VAL_EXT_W-1:0] D_FIRST  = VAL_EXT_W'(2);
    localparam logic [SQ_W-1:0]      SQ_FIRST = SQ_W'(4);

    // smallest half value with a non-empty divisor range
    localparam logic [VALUE_WIDTH-1:0] HALF_MIN_LOW  = VALUE_WIDTH'(3);
    localparam logic [VALUE_WIDTH-1:0] HALF_MIN_HIGH = VALUE_WIDTH'(2);

    typedef struct packed {
        logic                 start;
        logic [VAL_EXT_W-1:0] m;
        logic [VAL_EXT_W-1:0] lim;
    } trial_req_t;

    typedef struct packed {
        logic done;
        logic found;
    } trial_rsp_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_rsp_t;

endpackage

`default_nettype wire

// ===== sv/tpct_rem_serial.sv =====
// ----------------------------------------------------------------------------
// tpct_rem_serial: bit-serial remainder unit
// Restoring division, one dividend bit per cycle, reports a zero remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module tpct_rem_serial (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [tpct_pkg::VAL_EXT_W-1:0] dividend,
    input  wire logic [tpct_pkg::VAL_EXT_W-1:0] divisor,
    output tpct_pkg::rem_rsp_t                  rsp
);
    import tpct_pkg::*;

    logic [VAL_EXT_W-1:0] q_reg, q_next;
    logic [VAL_EXT_W-1:0] rem_reg, rem_next;
    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 zero_reg, zero_next;
    logic [VAL_EXT_W:0]   trial_val;
    logic [VAL_EXT_W:0]   diff;

    assign trial_val = {rem_reg, q_reg[VAL_EXT_W-1]};
    assign diff      = trial_val - {1'b0, divisor};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = REM_CNT_W'(VAL_EXT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // subtract when the partial remainder covers the divisor
            if (trial_val >= {1'b0, divisor})
                rem_next = diff[VAL_EXT_W-1:0];
            else
                rem_next = trial_val[VAL_EXT_W-1:0];
            q_next   = {q_reg[VAL_EXT_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == REM_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                zero_next = (rem_next == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        zero_reg <= zero_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero = zero_reg;

endmodule

`default_nettype wire

// ===== sv/tpct_trial.sv =====
// ----------------------------------------------------------------------------
// tpct_trial: trial division sequencer
// Steps the divisor from 2 up to the limit or the square root of m.
// ----------------------------------------------------------------------------
`default_nettype none

module tpct_trial (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tpct_pkg::trial_req_t req,
    output tpct_pkg::trial_rsp_t      rsp
);
    import tpct_pkg::*;

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_CHECK = 2'd1;
    localparam logic [1:0] T_WAIT  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [VAL_EXT_W-1:0] m_reg, m_next;
    logic [VAL_EXT_W-1:0] lim_reg, lim_next;
    logic [VAL_EXT_W-1:0] d_reg, d_next;
    logic [SQ_W-1:0]      sq_reg, sq_next;
    logic                 done_reg, done_next;
    logic                 found_reg, found_next;
    logic                 rem_start;
    logic                 d_in_range;
    rem_rsp_t             rem_rsp;

    assign d_in_range = (d_reg <= lim_reg);

    tpct_rem_serial u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (m_reg),
        .divisor  (d_reg),
        .rsp      (rem_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        lim_next   = lim_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        rem_start  = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (req.start)
                begin
                    m_next     = req.m;
                    lim_next   = req.lim;
                    d_next     = D_FIRST;
                    sq_next    = SQ_FIRST;
                    state_next = T_CHECK;
                end
            end
            T_CHECK:
            begin
                if (d_in_range && (sq_reg <= {1'b0, m_reg}))
                begin
                    rem_start  = 1'b1;
                    state_next = T_WAIT;
                end
                else
                begin
                    // no factor below the root: m is prime, its own divisor
                    done_next  = 1'b1;
                    found_next = d_in_range && (m_reg <= lim_reg);
                    state_next = T_IDLE;
                end
            end
            T_WAIT:
            begin
                if (rem_rsp.done)
                begin
                    if (rem_rsp.zero)
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b1;
                        state_next = T_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        sq_next    = sq_reg + {d_reg, 1'b0} + 1'b1;
                        state_next = T_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        lim_reg   <= lim_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        found_reg <= found_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.found = found_reg;

endmodule

`default_nettype wire

// ===== sv/twin_prime_candidate_test.sv =====
// ----------------------------------------------------------------------------
// twin_prime_candidate_test: twin pair test by serial trial division
// Tests n-1 and n+1 for divisors and keeps a saturating count of twin pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* carries one candidate n per transaction. The
//   block takes one candidate at a time: s_axis_tready is high only while
//   no candidate is being tested.
//   Master channel m_axis_* returns one result per candidate: the twin
//   flag in tuser, n-1 and the running pair count in tdata.
//   Each trial divisor runs through the bit-serial remainder unit, which
//   shifts in one dividend bit per cycle. n-1 is tried with divisors up to
//   min(sqrt(n-1), n/2-1), then n+1 up to min(sqrt(n+1), n/2), stopping
//   at the first divisor found. Large primes take up to some 65000
//   trials per number.
//   The result sits in an output register, so the next candidate is taken
//   while a result waits; if the receiver stalls, the finished result
//   after it holds until the register frees.
//   Reset clears the pair count, the output valid and the sequencers.
// ----------------------------------------------------------------------------
`default_nettype none

module twin_prime_candidate_test (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: candidate
    input  wire logic [tpct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: lower_member, pairs_found
    output logic [tpct_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: is_twin
    output logic                                  m_axis_tuser
);
    import tpct_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOW  = 2'd1;
    localparam logic [1:0] S_HIGH = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic                   twin_reg, twin_next;
    logic                   out_valid_reg, out_valid_next;
    logic [MEMBER_W-1:0]    lower_reg, lower_next;
    logic [CNT_W-1:0]       pairs_reg, pairs_next;
    logic                   out_twin_reg, out_twin_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] n_src;
    logic [VALUE_WIDTH-1:0] half_src;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   accept;
    trial_req_t             trial_req;
    trial_rsp_t             trial_rsp;

    assign accept   = s_axis_tvalid && s_axis_tready;
    // take the new candidate straight from the port in the accept cycle
    assign n_src    = (state_reg == S_IDLE) ? s_axis_tdata[VALUE_WIDTH-1:0] : n_reg;
    assign half_src = n_src >> 1;
    assign cnt_inc  = (twin_reg && (cnt_reg != '1)) ? cnt_reg + 1'b1 : cnt_reg;

    tpct_trial u_trial (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (trial_req),
        .rsp   (trial_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        twin_next      = twin_reg;
        cnt_next       = cnt_reg;
        lower_next     = lower_reg;
        pairs_next     = pairs_reg;
        out_twin_next  = out_twin_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        s_axis_tready  = (state_reg == S_IDLE);
        trial_req.start = 1'b0;
        trial_req.m     = VAL_EXT_W'(n_src) - 1'b1;
        trial_req.lim   = VAL_EXT_W'(half_src) - 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next = n_src;
                    if (half_src >= HALF_MIN_LOW)
                    begin
                        trial_req.start = 1'b1;
                        state_next      = S_LOW;
                    end
                    else if (half_src >= HALF_MIN_HIGH)
                    begin
                        trial_req.start = 1'b1;
                        trial_req.m     = VAL_EXT_W'(n_src) + 1'b1;
                        trial_req.lim   = VAL_EXT_W'(half_src);
                        state_next      = S_HIGH;
                    end
                    else
                    begin
                        // both ranges empty
                        twin_next  = 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_LOW:
            begin
                if (trial_rsp.done)
                begin
                    if (trial_rsp.found)
                    begin
                        twin_next  = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        trial_req.start = 1'b1;
                        trial_req.m     = VAL_EXT_W'(n_src) + 1'b1;
                        trial_req.lim   = VAL_EXT_W'(half_src);
                        state_next      = S_HIGH;
                    end
                end
            end
            S_HIGH:
            begin
                if (trial_rsp.done)
                begin
                    twin_next  = !trial_rsp.found;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    cnt_next       = cnt_inc;
                    lower_next     = MEMBER_W'(n_reg - 1'b1);
                    pairs_next     = cnt_inc;
                    out_twin_next  = twin_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        twin_reg     <= twin_next;
        lower_reg    <= lower_next;
        pairs_reg    <= pairs_next;
        out_twin_reg <= out_twin_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_twin_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({pairs_reg, lower_reg});

endmodule

`default_nettype wire

// ===== sv/tpct_checker.sv =====
// ----------------------------------------------------------------------------
// tpct_checker: port-level checks for the twin prime candidate test
// Watches handshakes and the pair count as seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tpct_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    // tdata: candidate
    input  wire logic [tpct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: lower_member, pairs_found
    input  wire logic [tpct_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: is_twin
    input  wire logic                             m_axis_tuser
);
    import tpct_pkg::*;

    logic [CNT_W-1:0] last_cnt_reg;
    logic [CNT_W-1:0] shown_cnt;
    logic [IN_TDATA_W-1:0] last_cand_reg;

    assign shown_cnt = m_axis_tdata[MEMBER_W +: CNT_W];

    // track the count of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_cnt_reg <= '0;
        else if (m_axis_tvalid && m_axis_tready)
            last_cnt_reg <= shown_cnt;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            last_cand_reg <= s_axis_tdata;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("candidate taken while another is under test");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (!m_axis_tuser && shown_cnt == last_cnt_reg) ||
            (m_axis_tuser && shown_cnt == last_cnt_reg + 1'b1) ||
            (m_axis_tuser && shown_cnt == '1 && last_cnt_reg == '1))
        else $error("pair count out of step with twin flag");

    a_lower_member: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            m_axis_tdata[MEMBER_W-1:0] ==
                MEMBER_W'(last_cand_reg[VALUE_WIDTH-1:0] - 1'b1))
        else $error("lower member does not match candidate");

endmodule

bind twin_prime_candidate_test tpct_checker u_tpct_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the twin prime candidate test
// Streams candidates through the slave channel in bursts, predicts each
// result with a trial-division model kept inside the bench or takes it from
// a typed table row, and checks every result field by field under random stalls.
// ----------------------------------------------------------------------------

module tb_top;

    import tpct_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 120;
    localparam int DRAIN_CYCLES  = 100;
    // Leave a wide margin over the longest small candidate.
    localparam int STUCK_LIMIT   = 100000;
    localparam int DIR_N         = 21;

    // One result transaction, in the order the master channel carries it.
    typedef struct packed {
        logic                is_twin;
        logic [MEMBER_W-1:0] lower_member;
        logic [CNT_W-1:0]    pairs_found;
    } twin_result_t;

    // One row of the directed table; typed rows carry a literal result.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] cand;
        logic                   typed;
        twin_result_t           res;
    } dir_row_t;

    // Receiver behavior modes.
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_CHOKE
    } sink_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b1;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    twin_result_t pending_results [$];
    logic [CNT_W-1:0] model_pairs = '0;
    int mismatch_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int twin_seen = 0;
    int stuck_cycles = 0;
    int burst_left = 0;

    // Directed table: tiny candidates where both ranges are empty, the zero
    // wrap of the lower member, all ones, small twin pairs and near misses,
    // and wide values whose neighbors fall to a small divisor quickly.
    dir_row_t dir_tab [DIR_N] = '{
        '{32'd0,          1'b1, '{1'b1, 32'hFFFF_FFFF, 32'd1}},
        '{32'd1,          1'b1, '{1'b1, 32'd0,         32'd2}},
        '{32'd2,          1'b1, '{1'b1, 32'd1,         32'd3}},
        '{32'd3,          1'b1, '{1'b1, 32'd2,         32'd4}},
        '{32'hFFFF_FFFF,  1'b1, '{1'b0, 32'hFFFF_FFFE, 32'd4}},
        '{32'd4,          1'b0, '0},
        '{32'd5,          1'b0, '0},
        '{32'd6,          1'b0, '0},
        '{32'd7,          1'b0, '0},
        '{32'd12,         1'b0, '0},
        '{32'd18,         1'b0, '0},
        '{32'd24,         1'b0, '0},
        '{32'd30,         1'b0, '0},
        '{32'd36,         1'b0, '0},
        '{32'd42,         1'b0, '0},
        '{32'd60,         1'b0, '0},
        '{32'd6000,       1'b0, '0},
        '{32'h8000_0001,  1'b0, '0},
        '{32'hFFFF_FFFA,  1'b0, '0},
        '{32'h5555_5555,  1'b0, '0},
        '{32'h2AAA_AAAB,  1'b0, '0}
    };

    twin_prime_candidate_test uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Pull reset low before the first clock edge, hold it, then release it for good.
    initial
    begin
        #1 rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // True when m has a divisor d with 2 <= d <= lim; stop at the root.
    function automatic bit has_factor_upto(longint unsigned m, longint unsigned lim);
        longint unsigned d;
        d = 2;
        while (d <= lim && d <= m / d)
        begin
            if (m % d == 0)
                return 1'b1;
            d++;
        end
        if (d > lim)
            return 1'b0;
        // no factor below the root: m is prime, its own divisor
        return m <= lim;
    endfunction

    // Work out the result for one candidate and advance the pair tally.
    function automatic twin_result_t predict_twin(logic [VALUE_WIDTH-1:0] cand);
        longint unsigned mask;
        longint unsigned n;
        longint unsigned half;
        longint unsigned up;
        bit low_div;
        bit high_div;
        twin_result_t r;
        mask = (VALUE_WIDTH >= 64) ? ~64'd0 : ((64'd1 << VALUE_WIDTH) - 64'd1);
        n = longint'(cand) & mask;
        half = n / 2;
        low_div = 1'b0;
        high_div = 1'b0;
        if (half >= 3)
            low_div = has_factor_upto(n - 1, half - 1);
        if (!low_div && half >= 2)
        begin
            up = n + 1;
            // n+1 can only wrap to zero at the full 64-bit width, and is even then
            if (up == 0)
                high_div = 1'b1;
            else
                high_div = has_factor_upto(up, half);
        end
        r.is_twin = !low_div && !high_div;
        if (r.is_twin && model_pairs != '1)
            model_pairs = model_pairs + 1'b1;
        r.lower_member = MEMBER_W'((n - 1) & mask);
        r.pairs_found = model_pairs;
        return r;
    endfunction

    // Pick one random candidate: mostly small multiples of six, which reach
    // the full two-sided test, plus wide values that fail fast and noise.
    function automatic logic [VALUE_WIDTH-1:0] pick_candidate();
        int unsigned roll;
        longint unsigned k;
        roll = $urandom_range(0, 99);
        if (roll < 58)
            return VALUE_WIDTH'(6 * $urandom_range(1, 1000));
        else if (roll < 68)
            return VALUE_WIDTH'($urandom_range(0, 40));
        else if (roll < 80)
            // odd: both neighbors are even, so the lower test ends at once
            return VALUE_WIDTH'($urandom) | VALUE_WIDTH'(1);
        else if (roll < 92)
        begin
            // n = 30k+6: a multiple of six with n-1 divisible by five
            k = $urandom_range(0, 143165575);
            return VALUE_WIDTH'(k * 30 + 6);
        end
        else
            // broken sequence: even, but off the multiples of six
            return VALUE_WIDTH'(6 * $urandom_range(1, 1000) + 2 * $urandom_range(1, 2));
    endfunction

    // Insert a gap between bursts; drop tvalid only when a gap starts.
    task automatic pace_source();
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 24 : $urandom_range(1, 6);
        end
        burst_left--;
    endtask

    // Queue the expected result and present the candidate until accepted.
    task automatic send_candidate(input logic [VALUE_WIDTH-1:0] cand, input bit typed,
                                  input twin_result_t typed_res);
        twin_result_t calc;
        calc = predict_twin(cand);
        pending_results.push_back(typed ? typed_res : calc);
        s_axis_tdata <= IN_TDATA_W'(cand);
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
    endtask

    // Hold the source until every queued result has come back.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Source: directed table first, then the random part, then the drain.
    initial
    begin : source
        int i;
        do
            @(posedge clk);
        while (!rst_n);

        for (i = 0; i < DIR_N; i++)
        begin
            pace_source();
            send_candidate(dir_tab[i].cand, dir_tab[i].typed, dir_tab[i].res);
        end

        hold_until_drained();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // pause once in the middle so the block fully empties mid-run
            if (i == RANDOM_ITEMS / 2)
                hold_until_drained();
            pace_source();
            send_candidate(pick_candidate(), 1'b0, '0);
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d candidates (directed edges plus random multiples of six,", sent_count);
        $display("wide fast-fail values and noise); %0d results checked, %0d twin pairs seen.",
                 checked_count, twin_seen);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Sink: the receiver alternates between open, coin-toss and choked runs.
    initial
    begin : sink
        sink_mode_t mode;
        int mode_left;
        mode = SINK_OPEN;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = sink_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:  m_axis_tready <= 1'b1;
                SINK_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
                SINK_CHOKE: m_axis_tready <= ($urandom_range(0, 15) == 0);
                default:    m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Checker: compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        twin_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            checked_count++;
            if (m_axis_tuser)
                twin_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: is_twin %0d, lower_member %0h, pairs_found %0d",
                       m_axis_tuser, m_axis_tdata[MEMBER_W-1:0],
                       m_axis_tdata[MEMBER_W +: CNT_W]);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.is_twin)
                begin
                    $error("is_twin: expected %0d, got %0d", want.is_twin, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata[MEMBER_W-1:0] !== want.lower_member)
                begin
                    $error("lower_member: expected %0h, got %0h", want.lower_member,
                           m_axis_tdata[MEMBER_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[MEMBER_W +: CNT_W] !== want.pairs_found)
                begin
                    $error("pairs_found: expected %0d, got %0d", want.pairs_found,
                           m_axis_tdata[MEMBER_W +: CNT_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long.
    always @(posedge clk)
    begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
